/* rtl/core/i2p_pkg.sv */
// Shared types, character codes and lookup functions for the infix to postfix converter.
// No dependencies; imported by every module of the block except i2p_ram.
`timescale 1ns / 1ps

package i2p_pkg;

   localparam int DEFAULT_STACK_DEPTH = 16;

   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_OVERFLOW = 2'd1;
   localparam logic [1:0] ERR_PAREN    = 2'd2;

   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_POW    = 8'h5E;
   localparam logic [7:0] CH_MUL    = 8'h2A;
   localparam logic [7:0] CH_DIV    = 8'h2F;
   localparam logic [7:0] CH_ADD    = 8'h2B;
   localparam logic [7:0] CH_SUB    = 8'h2D;

   typedef enum logic [2:0] {
      OP_LPAREN = 3'd0,
      OP_POW    = 3'd1,
      OP_MUL    = 3'd2,
      OP_DIV    = 3'd3,
      OP_ADD    = 3'd4,
      OP_SUB    = 3'd5,
      OP_NONE   = 3'd7
   } op_type;

   typedef enum logic [2:0] {
      CLS_NONE,
      CLS_ALNUM,
      CLS_LPAREN,
      CLS_RPAREN,
      CLS_OPER
   } class_type;

   typedef struct packed {
      logic latch;
      logic decide;
      logic to_pend;
      logic emit_top;
      logic pop;
      logic push;
      logic drain;
      logic clear;
   } dp_cmd_type;

   typedef struct packed {
      class_type cls;
      logic      last;
      logic      sp_zero;
      logic      sp_full;
      logic      top_lp;
      logic      top_ok;
      logic      pop_ok;
      logic      out_free;
      logic      pend_v;
   } dp_stat_type;

   function automatic op_type op_of_char(input logic [7:0] c);
      op_type r;
      case (c)
         CH_LPAREN: r = OP_LPAREN;
         CH_POW:    r = OP_POW;
         CH_MUL:    r = OP_MUL;
         CH_DIV:    r = OP_DIV;
         CH_ADD:    r = OP_ADD;
         CH_SUB:    r = OP_SUB;
         default:   r = OP_NONE;
      endcase
      return r;
   endfunction

   function automatic class_type char_class(input logic [7:0] c);
      class_type r;
      if (c inside {[8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39]}) begin
         r = CLS_ALNUM;
      end else begin
         case (c)
            CH_LPAREN: r = CLS_LPAREN;
            CH_RPAREN: r = CLS_RPAREN;
            CH_POW, CH_MUL, CH_DIV, CH_ADD, CH_SUB: r = CLS_OPER;
            default:   r = CLS_NONE;
         endcase
      end
      return r;
   endfunction

   function automatic logic [7:0] op_char(input op_type op);
      logic [7:0] r;
      case (op)
         OP_LPAREN: r = CH_LPAREN;
         OP_POW:    r = CH_POW;
         OP_MUL:    r = CH_MUL;
         OP_DIV:    r = CH_DIV;
         OP_ADD:    r = CH_ADD;
         OP_SUB:    r = CH_SUB;
         default:   r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic logic [1:0] op_prec(input op_type op);
      logic [1:0] r;
      case (op)
         OP_POW:         r = 2'd3;
         OP_MUL, OP_DIV: r = 2'd2;
         OP_ADD, OP_SUB: r = 2'd1;
         default:        r = 2'd0;
      endcase
      return r;
   endfunction

endpackage

/* rtl/core/i2p_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module i2p_ram #(
   parameter int WIDTH = 3,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

/* rtl/core/i2p_dpath.sv */
// Datapath: input latch, operator stack RAM with pointer and paren count, sticky error,
// pending result and output register. Depends on i2p_pkg and i2p_ram.
`timescale 1ns / 1ps

module i2p_dpath
   import i2p_pkg::*;
#(
   parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  dp_cmd_type  cmd,
   output dp_stat_type stat,
   input  logic [7:0]  req_char_in,
   input  logic        req_end_of_expr,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_char_out,
   output logic        rsp_has_char,
   output logic        rsp_expr_done,
   output logic [1:0]  rsp_error_code
);

   localparam int SP_W = $clog2(STACK_DEPTH + 1);
   localparam int AW   = $clog2(STACK_DEPTH);

   logic [7:0]      char_ff;
   logic            last_ff;
   logic [SP_W-1:0] sp_ff, sp_in;
   logic [SP_W-1:0] lp_ff, lp_in;
   logic [1:0]      err_ff, err_in;
   logic            chg_ff;
   logic            pend_v_ff, pend_v_in;
   logic [7:0]      pend_ch_ff, pend_ch_in;
   logic            out_v_ff, out_v_in;
   logic [7:0]      out_ch_ff, out_ch_in;
   logic            out_has_ff, out_has_in;
   logic            out_done_ff, out_done_in;
   logic [1:0]      out_err_ff;
   logic            load;

   logic [2:0]      rdata;
   op_type          top;
   op_type          code;
   class_type       cls;
   logic            sp_zero, sp_full, top_lp, pop_ok;
   logic [1:0]      step_err, end_err;
   logic [SP_W-1:0] lp_after;
   logic [SP_W-1:0] rd_ptr;

   assign top     = op_type'(rdata);
   assign code    = op_of_char(char_ff);
   assign cls     = char_class(char_ff);
   assign sp_zero = (sp_ff == '0);
   assign sp_full = (sp_ff == SP_W'(STACK_DEPTH));
   assign top_lp  = (top == OP_LPAREN);
   assign pop_ok  = (op_prec(top) > op_prec(code))
                 || ((op_prec(top) == op_prec(code)) && (code != OP_POW));
   assign rd_ptr  = sp_ff - SP_W'(1);

   i2p_ram #(
      .WIDTH(3),
      .DEPTH(STACK_DEPTH)
   ) u_stack (
      .clock(clock),
      .we   (cmd.push),
      .waddr(sp_ff[AW-1:0]),
      .wdata(code),
      .raddr(rd_ptr[AW-1:0]),
      .rdata(rdata)
   );

   always_comb begin
      step_err = ERR_NONE;
      lp_after = lp_ff;
      case (cls)
         CLS_RPAREN: begin
            if (lp_ff == '0) begin
               step_err = ERR_PAREN;
            end else begin
               lp_after = lp_ff - SP_W'(1);
            end
         end
         CLS_LPAREN: begin
            if (sp_full) begin
               step_err = ERR_OVERFLOW;
            end else begin
               lp_after = lp_ff + SP_W'(1);
            end
         end
         CLS_OPER: begin
            if (sp_full && (top_lp || !pop_ok)) begin
               step_err = ERR_OVERFLOW;
            end
         end
         default: begin
            step_err = ERR_NONE;
         end
      endcase
      end_err = (last_ff && (lp_after != '0)) ? ERR_PAREN : ERR_NONE;
   end

   always_comb begin
      err_in = err_ff;
      if (cmd.decide && (err_ff == ERR_NONE)) begin
         err_in = (step_err != ERR_NONE) ? step_err : end_err;
      end
      sp_in = sp_ff;
      lp_in = lp_ff;
      if (cmd.pop) begin
         sp_in = sp_ff - SP_W'(1);
         if (top_lp) begin
            lp_in = lp_ff - SP_W'(1);
         end
      end else if (cmd.push) begin
         sp_in = sp_ff + SP_W'(1);
         if (code == OP_LPAREN) begin
            lp_in = lp_ff + SP_W'(1);
         end
      end
      if (cmd.clear) begin
         sp_in  = '0;
         lp_in  = '0;
         err_in = ERR_NONE;
      end
   end

   always_comb begin
      pend_v_in   = pend_v_ff;
      pend_ch_in  = pend_ch_ff;
      load        = 1'b0;
      out_ch_in   = pend_ch_ff;
      out_has_in  = 1'b1;
      out_done_in = 1'b0;
      if (cmd.to_pend || cmd.emit_top) begin
         pend_v_in  = 1'b1;
         pend_ch_in = cmd.to_pend ? char_ff : op_char(top);
         load       = pend_v_ff;
      end else if (cmd.drain) begin
         pend_v_in   = 1'b0;
         load        = pend_v_ff || last_ff;
         out_done_in = last_ff;
         if (!pend_v_ff) begin
            out_ch_in  = 8'h00;
            out_has_in = 1'b0;
         end
      end
      if (load) begin
         out_v_in = 1'b1;
      end else if (rsp_ready) begin
         out_v_in = 1'b0;
      end else begin
         out_v_in = out_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff     <= '0;
         lp_ff     <= '0;
         err_ff    <= ERR_NONE;
         chg_ff    <= 1'b1;
         pend_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         sp_ff     <= sp_in;
         lp_ff     <= lp_in;
         err_ff    <= err_in;
         chg_ff    <= cmd.pop || cmd.push || cmd.clear;
         pend_v_ff <= pend_v_in;
         out_v_ff  <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         char_ff <= req_char_in;
         last_ff <= req_end_of_expr;
      end
      pend_ch_ff <= pend_ch_in;
      if (load) begin
         out_ch_ff   <= out_ch_in;
         out_has_ff  <= out_has_in;
         out_done_ff <= out_done_in;
         out_err_ff  <= err_ff;
      end
   end

   assign stat.cls      = cls;
   assign stat.last     = last_ff;
   assign stat.sp_zero  = sp_zero;
   assign stat.sp_full  = sp_full;
   assign stat.top_lp   = top_lp;
   assign stat.top_ok   = !chg_ff;
   assign stat.pop_ok   = pop_ok;
   assign stat.out_free = !out_v_ff || rsp_ready;
   assign stat.pend_v   = pend_v_ff;

   assign rsp_valid      = out_v_ff;
   assign rsp_char_out   = out_ch_ff;
   assign rsp_has_char   = out_has_ff;
   assign rsp_expr_done  = out_done_ff;
   assign rsp_error_code = out_err_ff;

endmodule

/* rtl/core/i2p_ctrl.sv */
// Controller: sequences accept, classify, pop loops, push, flush and drain per character.
// Depends on i2p_pkg.
`timescale 1ns / 1ps

module i2p_ctrl
   import i2p_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_RPOP,
      ST_OPOP,
      ST_FLUSH,
      ST_DRAIN
   } state_type;

   state_type state_ff, state_in;
   state_type after;
   logic      emit_ok;
   logic      drain_ok;

   assign after    = stat.last ? ST_FLUSH : ST_DRAIN;
   assign emit_ok  = !stat.pend_v || stat.out_free;
   assign drain_ok = (!stat.pend_v && !stat.last) || stat.out_free;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (stat.top_ok) begin
               cmd.decide = 1'b1;
               case (stat.cls)
                  CLS_ALNUM: begin
                     cmd.to_pend = 1'b1;
                     state_in    = after;
                  end
                  CLS_RPAREN: state_in = ST_RPOP;
                  CLS_OPER:   state_in = ST_OPOP;
                  CLS_LPAREN: begin
                     cmd.push = !stat.sp_full;
                     state_in = after;
                  end
                  default: state_in = after;
               endcase
            end
         end
         ST_RPOP: begin
            if (stat.top_ok) begin
               if (stat.sp_zero) begin
                  state_in = after;
               end else if (stat.top_lp) begin
                  cmd.pop  = 1'b1;
                  state_in = after;
               end else if (emit_ok) begin
                  cmd.emit_top = 1'b1;
                  cmd.pop      = 1'b1;
               end
            end
         end
         ST_OPOP: begin
            if (stat.top_ok) begin
               if (!stat.sp_zero && !stat.top_lp && stat.pop_ok) begin
                  if (emit_ok) begin
                     cmd.emit_top = 1'b1;
                     cmd.pop      = 1'b1;
                  end
               end else begin
                  cmd.push = !stat.sp_full;
                  state_in = after;
               end
            end
         end
         ST_FLUSH: begin
            if (stat.top_ok) begin
               if (stat.sp_zero) begin
                  state_in = ST_DRAIN;
               end else if (stat.top_lp) begin
                  cmd.pop = 1'b1;
               end else if (emit_ok) begin
                  cmd.emit_top = 1'b1;
                  cmd.pop      = 1'b1;
               end
            end
         end
         ST_DRAIN: begin
            if (drain_ok) begin
               cmd.drain = 1'b1;
               cmd.clear = stat.last;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

endmodule

/* rtl/core/infix_to_postfix_converter.sv */
// Top level of the infix to postfix converter: controller plus datapath.
// Depends on i2p_pkg, i2p_ctrl, i2p_dpath (and i2p_ram below it).
//
//   channel   ports                                     direction
//   req       req_valid/ready, char_in, end_of_expr     in, one character per transfer
//   rsp       rsp_valid/ready, char_out, has_char,      out, one postfix character
//             expr_done, error_code                     or bare end marker per transfer
//
// A character passes through accept, decide and drain; an operator or ')' adds its pop phase,
// and a final character adds the flush with its empty-stack check. Each operator popped
// out and each '(' dropped by the flush also waits for the registered stack read to settle,
// as does the first stack check after a push or pop right before the flush.
// Synchronous active-high reset clears pointer, paren count, error and valids.
// A stalled rsp holds the controller wherever a new result must enter the output register.
`timescale 1ns / 1ps

module infix_to_postfix_converter
   import i2p_pkg::*;
#(
   parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_char_in,
   input  logic       req_end_of_expr,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_char_out,
   output logic       rsp_has_char,
   output logic       rsp_expr_done,
   output logic [1:0] rsp_error_code
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   i2p_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .stat     (stat),
      .cmd      (cmd)
   );

   i2p_dpath #(
      .STACK_DEPTH(STACK_DEPTH)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_char_in    (req_char_in),
      .req_end_of_expr(req_end_of_expr),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_char_out   (rsp_char_out),
      .rsp_has_char   (rsp_has_char),
      .rsp_expr_done  (rsp_expr_done),
      .rsp_error_code (rsp_error_code)
   );

   a_bare_marker: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_has_char) |-> (rsp_expr_done && (rsp_char_out == 8'h00)))
      else $error("bare result without end mark");

   a_err_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_error_code == ERR_NONE) || (rsp_error_code == ERR_OVERFLOW)
                     || (rsp_error_code == ERR_PAREN)))
      else $error("invalid error code");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second transfer accepted during work");

endmodule

/* dv/infix_to_postfix_converter_test.sv */
// Self-checking testbench for infix_to_postfix_converter: directed and random expressions
// are sent one character per transfer and every postfix result is checked against a predictor.
// Depends on i2p_pkg and the converter RTL.
`timescale 1ns / 1ps

module infix_to_postfix_converter_test;
   import i2p_pkg::*;

   localparam int DEPTH       = DEFAULT_STACK_DEPTH;
   localparam int QUIET_LIMIT = 4000;
   localparam int TAIL_CYCLES = 60;
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic [7:0] ch;
      logic       has;
      logic       done;
      logic [1:0] err;
   } postfix_sym_type;

   typedef logic [7:0] text_type[$];

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_char_in = 8'h00;
   logic       req_end_of_expr = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_char_out;
   logic       rsp_has_char;
   logic       rsp_expr_done;
   logic [1:0] rsp_error_code;

   op_type          op_stack [DEPTH];
   int              op_depth;
   logic [1:0]      sticky_err;
   postfix_sym_type pending_postfix[$];
   text_type        expr_text;

   int idle_pct;
   int stall_pct;
   int token_count;
   int expr_count;
   int result_count;
   int overflow_exprs;
   int paren_exprs;
   int fail_count;

   infix_to_postfix_converter #(
      .STACK_DEPTH(DEPTH)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_char_in     (req_char_in),
      .req_end_of_expr (req_end_of_expr),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_char_out    (rsp_char_out),
      .rsp_has_char    (rsp_has_char),
      .rsp_expr_done   (rsp_expr_done),
      .rsp_error_code  (rsp_error_code)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic is_alnum(input logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || (c >= "0" && c <= "9");
   endfunction

   function automatic op_type op_code(input logic [7:0] c);
      case (c)
         CH_LPAREN: return OP_LPAREN;
         CH_POW:    return OP_POW;
         CH_MUL:    return OP_MUL;
         CH_DIV:    return OP_DIV;
         CH_ADD:    return OP_ADD;
         CH_SUB:    return OP_SUB;
         default:   return OP_NONE;
      endcase
   endfunction

   function automatic logic [7:0] sym_of(input op_type op);
      case (op)
         OP_POW:  return CH_POW;
         OP_MUL:  return CH_MUL;
         OP_DIV:  return CH_DIV;
         OP_ADD:  return CH_ADD;
         OP_SUB:  return CH_SUB;
         default: return CH_LPAREN;
      endcase
   endfunction

   function automatic int binding(input op_type op);
      case (op)
         OP_POW:         return 3;
         OP_MUL, OP_DIV: return 2;
         OP_ADD, OP_SUB: return 1;
         default:        return 0;
      endcase
   endfunction

   function automatic postfix_sym_type postfix_sym(input logic [7:0] c, input logic has);
      postfix_sym_type s;
      s.ch   = c;
      s.has  = has;
      s.done = 1'b0;
      s.err  = ERR_NONE;
      return s;
   endfunction

   function automatic void note_error(input logic [1:0] code);
      if (sticky_err == ERR_NONE) begin
         sticky_err = code;
      end
   endfunction

   // Work out the postfix results of one accepted character.
   function automatic void convert_char(input logic [7:0] c, input logic last);
      postfix_sym_type step_out[$];
      postfix_sym_type tail;
      op_type          code;
      op_type          top;
      logic            closed;
      code = op_code(c);
      if (is_alnum(c)) begin
         step_out.push_back(postfix_sym(c, 1'b1));
      end else if (c == CH_RPAREN) begin
         closed = 1'b0;
         while (op_depth > 0 && !closed) begin
            op_depth--;
            top = op_stack[op_depth];
            if (top == OP_LPAREN) begin
               closed = 1'b1;
            end else begin
               step_out.push_back(postfix_sym(sym_of(top), 1'b1));
            end
         end
         if (!closed) begin
            note_error(ERR_PAREN);
         end
      end else if (code != OP_NONE) begin
         if (code != OP_LPAREN) begin
            while (op_depth > 0 && op_stack[op_depth - 1] != OP_LPAREN &&
                   (binding(op_stack[op_depth - 1]) > binding(code) ||
                    (binding(op_stack[op_depth - 1]) == binding(code) && code != OP_POW))) begin
               op_depth--;
               step_out.push_back(postfix_sym(sym_of(op_stack[op_depth]), 1'b1));
            end
         end
         if (op_depth >= DEPTH) begin
            note_error(ERR_OVERFLOW);
         end else begin
            op_stack[op_depth] = code;
            op_depth++;
         end
      end
      if (last) begin
         while (op_depth > 0) begin
            op_depth--;
            if (op_stack[op_depth] == OP_LPAREN) begin
               note_error(ERR_PAREN);
            end else begin
               step_out.push_back(postfix_sym(sym_of(op_stack[op_depth]), 1'b1));
            end
         end
         if (step_out.size() == 0) begin
            step_out.push_back(postfix_sym(8'h00, 1'b0));
         end
         tail = step_out.pop_back();
         tail.done = 1'b1;
         step_out.push_back(tail);
      end
      foreach (step_out[i]) begin
         tail = step_out[i];
         tail.err = sticky_err;
         pending_postfix.push_back(tail);
      end
      if (last) begin
         expr_count++;
         if (sticky_err == ERR_OVERFLOW) begin
            overflow_exprs++;
         end else if (sticky_err == ERR_PAREN) begin
            paren_exprs++;
         end
         op_depth   = 0;
         sticky_err = ERR_NONE;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         convert_char(req_char_in, req_end_of_expr);
      end
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin : check_postfix
      postfix_sym_type want;
      postfix_sym_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.ch   = rsp_char_out;
         got.has  = rsp_has_char;
         got.done = rsp_expr_done;
         got.err  = rsp_error_code;
         result_count++;
         if (pending_postfix.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
               $display("unexpected result: ch=%h has=%b done=%b err=%0d",
                        got.ch, got.has, got.done, got.err);
            end
         end else begin
            want = pending_postfix.pop_front();
            if (want.ch !== got.ch || want.has !== got.has ||
                want.done !== got.done || want.err !== got.err) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS) begin
                  $display("mismatch: expected ch=%h has=%b done=%b err=%0d",
                           want.ch, want.has, want.done, want.err);
                  $display("          actual   ch=%h has=%b done=%b err=%0d",
                           got.ch, got.has, got.done, got.err);
               end
            end
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("Regression FAIL");
      $finish;
   end

   // Hold valid through the transfer; drop it only when an idle gap follows.
   task automatic send_char(input logic [7:0] c, input logic last);
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         do begin
            @(posedge clock);
         end while ($urandom_range(99) < idle_pct);
      end
      req_valid       <= 1'b1;
      req_char_in     <= c;
      req_end_of_expr <= last;
      do begin
         @(posedge clock);
      end while (!req_ready);
      token_count++;
   endtask

   task automatic send_expr(input text_type t);
      foreach (t[i]) begin
         send_char(t[i], i == t.size() - 1);
      end
   endtask

   function automatic text_type to_text(input string s);
      text_type t;
      for (int i = 0; i < s.len(); i++) begin
         t.push_back(s[i]);
      end
      return t;
   endfunction

   function automatic logic [7:0] rand_operand();
      int k;
      k = $urandom_range(61);
      if (k < 10) begin
         return 8'("0" + k);
      end else if (k < 36) begin
         return 8'("A" + k - 10);
      end
      return 8'("a" + k - 36);
   endfunction

   function automatic logic [7:0] rand_oper();
      case ($urandom_range(4))
         0:       return CH_POW;
         1:       return CH_MUL;
         2:       return CH_DIV;
         3:       return CH_ADD;
         default: return CH_SUB;
      endcase
   endfunction

   // Mostly balanced expressions with random content; the rest broken token runs or raw bytes.
   task automatic build_random_expr();
      int pick;
      int opens;
      int operands;
      int i;
      expr_text.delete();
      pick = $urandom_range(99);
      if (pick < 75) begin
         opens    = 0;
         operands = $urandom_range(1, 7);
         for (i = 0; i < operands; i++) begin
            while (opens < 18 && $urandom_range(3) == 0) begin
               expr_text.push_back(CH_LPAREN);
               opens++;
            end
            expr_text.push_back(rand_operand());
            while (opens > 0 && $urandom_range(2) == 0) begin
               expr_text.push_back(CH_RPAREN);
               opens--;
            end
            if (i < operands - 1) begin
               expr_text.push_back(rand_oper());
            end
         end
         while (opens > 0 && $urandom_range(9) != 0) begin
            expr_text.push_back(CH_RPAREN);
            opens--;
         end
         if ($urandom_range(4) == 0) begin
            expr_text.insert($urandom_range(expr_text.size()), 8'($urandom_range(255)));
         end
      end else if (pick < 92) begin
         for (i = $urandom_range(1, 8); i > 0; i--) begin
            case ($urandom_range(3))
               0:       expr_text.push_back(CH_LPAREN);
               1:       expr_text.push_back(CH_RPAREN);
               2:       expr_text.push_back(rand_oper());
               default: expr_text.push_back(rand_operand());
            endcase
         end
      end else begin
         for (i = $urandom_range(1, 4); i > 0; i--) begin
            expr_text.push_back(8'($urandom_range(255)));
         end
      end
   endtask

   task automatic test_operators();
      send_expr(to_text("A^9^z*0/a-Z+b"));
      send_expr(to_text("(c)"));
   endtask

   task automatic test_special_cases();
      send_char(8'hFF, 1'b0);
      send_char(CH_RPAREN, 1'b1);
      send_expr(to_text("(a"));
      send_char(8'h00, 1'b1);
      send_char(8'h20, 1'b1);
   endtask

   task automatic test_full_stack_flush();
      text_type t;
      for (int i = 0; i < DEPTH; i++) begin
         t.push_back(rand_operand());
         t.push_back(CH_POW);
      end
      t.push_back("y");
      send_expr(t);
   endtask

   task automatic test_overflow();
      text_type t;
      for (int i = 0; i <= DEPTH; i++) begin
         t.push_back(CH_LPAREN);
      end
      t.push_back(CH_POW);
      t.push_back("x");
      send_expr(t);
   endtask

   task automatic test_random(input int count, input int idle, input int stall);
      int start;
      idle_pct  = idle;
      stall_pct = stall;
      start     = token_count;
      while (token_count - start < count) begin
         build_random_expr();
         send_expr(expr_text);
      end
   endtask

   initial begin
      idle_pct  = 0;
      stall_pct = 0;
      op_depth  = 0;
      sticky_err = ERR_NONE;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_operators();
      test_special_cases();
      test_full_stack_flush();
      test_overflow();
      test_random(45, 0, 0);
      test_random(45, 75, 0);
      test_random(45, 0, 75);
      test_random(45, 37, 37);

      req_valid <= 1'b0;
      while (pending_postfix.size() != 0) begin
         @(posedge clock);
      end
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d expressions (%0d characters), checked %0d postfix results",
               expr_count, token_count, result_count);
      $display("Overflow expressions: %0d, unbalanced-parenthesis expressions: %0d",
               overflow_exprs, paren_exprs);
      if (fail_count == 0 && pending_postfix.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d mismatches, %0d results never seen", fail_count,
                  pending_postfix.size());
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/core/i2p_pkg.sv
rtl/core/i2p_ram.sv
rtl/core/i2p_dpath.sv
rtl/core/i2p_ctrl.sv
rtl/core/infix_to_postfix_converter.sv
dv/infix_to_postfix_converter_test.sv
